### hw/rtl/lfs_pkg.sv
// Shared types, codes and constants for the line-follow steering block.
`default_nettype none

package lfs_pkg;

    // Field and register widths
    localparam int FUNC_W     = 2;
    localparam int BITS_W     = 8;
    localparam int DUTY_W     = 11;
    localparam int ERR_W      = 7;
    localparam int HEAD_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 4;
    localparam int DIV_CNT_W  = 3;
    localparam int PROD_W     = 14;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

    // Heading codes
    localparam logic [HEAD_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_DUTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT  = 3'd5;

    // Configuration reset values
    localparam logic [9:0] BASE_DUTY_RST   = 10'd260;
    localparam logic [7:0] RAMP_STEP_RST   = 8'd10;
    localparam logic [5:0] STEER_GAIN_RST  = 6'd12;
    localparam logic [9:0] STEER_LIMIT_RST = 10'd500;
    localparam logic [9:0] SEARCH_DUTY_RST = 10'd180;
    localparam logic [9:0] DUTY_LIMIT_RST  = 10'd1000;

    // Error band for heading
    localparam logic signed [ERR_W-1:0] DIR_BAND_LO = -7'sd8;
    localparam logic signed [ERR_W-1:0] DIR_BAND_HI = 7'sd8;

    // Sensor weights, bit 0 is the leftmost sensor
    localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [BITS_W] = '{
        -7'sd35, -7'sd25, -7'sd15, -7'sd5, 7'sd5, 7'sd15, 7'sd25, 7'sd35
    };

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic cor;
        logic tgt;
        logic commit;
    } lfs_cmd_t;

    typedef struct packed {
        logic need_avg;
        logic is_tick;
        logic div_last;
        logic out_free;
    } lfs_status_t;

endpackage

`default_nettype wire

### hw/rtl/lfs_ctrl.sv
// Sequencer for the line-follow steering block.
`default_nettype none

module lfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfs_pkg::lfs_status_t st,
    output lfs_pkg::lfs_cmd_t    cmd
);
    import lfs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL  = 6'b000100,
        S_COR  = 6'b001000,
        S_TGT  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!st.need_avg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (st.div_last)
                    begin
                        state_next = st.is_tick ? S_MUL : S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_COR;
            end
            S_COR:
            begin
                cmd.cor    = 1'b1;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.tgt    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lfs_dp.sv
// Datapath for the line-follow steering block: registers, divider, steering math.
`default_nettype none

module lfs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [lfs_pkg::FUNC_W-1:0]          func,
    input  logic [lfs_pkg::BITS_W-1:0]          sensor_word,
    input  logic                                out_ready,
    input  lfs_pkg::lfs_cmd_t                   cmd,
    output lfs_pkg::lfs_status_t                st,
    output logic                                out_valid,
    output logic signed [lfs_pkg::DUTY_W-1:0]   left_duty,
    output logic signed [lfs_pkg::DUTY_W-1:0]   right_duty,
    output logic signed [lfs_pkg::ERR_W-1:0]    line_error,
    output logic [lfs_pkg::HEAD_W-1:0]          heading,
    output logic                                line_found
);
    import lfs_pkg::*;

    function automatic logic signed [DUTY_W-1:0] clamp_duty(
        input logic signed [DUTY_W:0] v,
        input logic [9:0]             lim
    );
        logic signed [DUTY_W:0] lim_s;
        logic signed [DUTY_W:0] r;
        lim_s = $signed({2'b00, lim});
        if (v < -lim_s)
            r = -lim_s;
        else if (v > lim_s)
            r = lim_s;
        else
            r = v;
        return r[DUTY_W-1:0];
    endfunction

    function automatic logic signed [DUTY_W-1:0] ramp_toward(
        input logic signed [DUTY_W-1:0] cur,
        input logic signed [DUTY_W-1:0] tgt,
        input logic [7:0]               step
    );
        logic signed [DUTY_W+1:0] s;
        logic signed [DUTY_W+1:0] t;
        logic signed [DUTY_W+1:0] d;
        t = (DUTY_W+2)'(tgt);
        d = $signed({5'b00000, step});
        s = (DUTY_W+2)'(cur);
        if (cur < tgt)
        begin
            s = s + d;
            if (s > t)
                s = t;
        end
        else if (cur > tgt)
        begin
            s = s - d;
            if (s < t)
                s = t;
        end
        return s[DUTY_W-1:0];
    endfunction

    function automatic logic [HEAD_W-1:0] dir_of(input logic signed [ERR_W-1:0] e);
        logic [HEAD_W-1:0] d;
        if (e < DIR_BAND_LO)
            d = DIR_LEFT;
        else if (e > DIR_BAND_HI)
            d = DIR_RIGHT;
        else
            d = DIR_FWD;
        return d;
    endfunction

    // Configuration registers
    logic [9:0] base_duty_reg;
    logic [7:0] ramp_step_reg;
    logic [5:0] steer_gain_reg;
    logic [9:0] steer_limit_reg;
    logic [9:0] search_duty_reg;
    logic [9:0] duty_limit_reg;

    // Follower state
    logic signed [DUTY_W-1:0] left_now_reg;
    logic signed [DUTY_W-1:0] right_now_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [ERR_W-1:0]  cur_err_reg;
    logic                     seen_reg;
    logic                     running_reg;
    logic [HEAD_W-1:0]        dir_reg;
    logic                     out_valid_reg;
    logic                     line_found_reg;

    // Per-request working registers
    logic [FUNC_W-1:0]        func_reg;
    logic                     found_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [BITS_W-1:0]        dvd_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [BITS_W-1:0]        quot_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DUTY_W-1:0] corr_reg;
    logic signed [DUTY_W-1:0] tl_reg;
    logic signed [DUTY_W-1:0] tr_reg;

    logic signed [8:0]        w_sum;
    logic signed [8:0]        abs_sum;
    logic [CNT_W-1:0]         w_cnt;
    logic [CNT_W:0]           trial;
    logic                     trial_ge;
    logic [ERR_W-1:0]         q_mag;
    logic signed [ERR_W-1:0]  err_val;
    logic signed [PROD_W-1:0] slim;
    logic signed [PROD_W-1:0] corr_w;
    logic signed [DUTY_W:0]   sum_l;
    logic signed [DUTY_W:0]   sum_r;
    logic signed [DUTY_W-1:0] search_s;
    logic signed [DUTY_W-1:0] half_s;
    logic signed [DUTY_W-1:0] tl_next;
    logic signed [DUTY_W-1:0] tr_next;
    logic                     is_tick;
    logic                     is_start;
    logic                     is_stop;

    assign is_tick  = (func_reg == FUNC_TICK);
    assign is_start = (func_reg == FUNC_START);
    assign is_stop  = (func_reg == FUNC_STOP);

    assign st.need_avg = (is_tick && running_reg) || (is_start && !running_reg);
    assign st.is_tick  = is_tick;
    assign st.div_last = (div_cnt_reg == {DIV_CNT_W{1'b1}});
    assign st.out_free = !out_valid_reg || out_ready;

    // Weighted sum and count of active sensors
    always_comb
    begin
        w_sum = '0;
        w_cnt = '0;
        for (int i = 0; i < BITS_W; i++)
        begin
            if (sensor_word[i])
            begin
                w_sum = w_sum + 9'(SENSOR_WEIGHT[i]);
                w_cnt = w_cnt + 4'd1;
            end
        end
        abs_sum = w_sum[8] ? -w_sum : w_sum;
    end

    // Restoring divide step on the magnitude
    assign trial    = {rem_reg, dvd_reg[BITS_W-1]};
    assign trial_ge = (trial >= {1'b0, cnt_reg});

    // Truncate toward zero: divide the magnitude, then restore the sign
    assign q_mag   = {1'b0, quot_reg[5:0]};
    assign err_val = neg_reg ? $signed(7'd0 - q_mag) : $signed(q_mag);

    assign slim = $signed({4'b0000, steer_limit_reg});

    always_comb
    begin
        if (prod_reg > slim)
            corr_w = slim;
        else if (prod_reg < -slim)
            corr_w = -slim;
        else
            corr_w = prod_reg;
    end

    assign sum_l    = $signed({2'b00, base_duty_reg}) + (DUTY_W+1)'(corr_reg);
    assign sum_r    = $signed({2'b00, base_duty_reg}) - (DUTY_W+1)'(corr_reg);
    assign search_s = $signed({1'b0, search_duty_reg});
    assign half_s   = $signed({2'b00, base_duty_reg[9:1]});

    always_comb
    begin
        if (found_reg)
        begin
            tl_next = clamp_duty(sum_l, duty_limit_reg);
            tr_next = clamp_duty(sum_r, duty_limit_reg);
        end
        else if (seen_reg)
        begin
            // spin toward the side where the line was last seen
            if (last_err_reg < 0)
            begin
                tl_next = -search_s;
                tr_next = search_s;
            end
            else
            begin
                tl_next = search_s;
                tr_next = -search_s;
            end
        end
        else
        begin
            tl_next = half_s;
            tr_next = half_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_duty_reg   <= BASE_DUTY_RST;
            ramp_step_reg   <= RAMP_STEP_RST;
            steer_gain_reg  <= STEER_GAIN_RST;
            steer_limit_reg <= STEER_LIMIT_RST;
            search_duty_reg <= SEARCH_DUTY_RST;
            duty_limit_reg  <= DUTY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BASE_DUTY:   base_duty_reg   <= cfg_wdata[9:0];
                CFG_RAMP_STEP:   ramp_step_reg   <= cfg_wdata[7:0];
                CFG_STEER_GAIN:  steer_gain_reg  <= cfg_wdata[5:0];
                CFG_STEER_LIMIT: steer_limit_reg <= cfg_wdata[9:0];
                CFG_SEARCH_DUTY: search_duty_reg <= cfg_wdata[9:0];
                CFG_DUTY_LIMIT:  duty_limit_reg  <= cfg_wdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            found_reg   <= (sensor_word != '0);
            neg_reg     <= w_sum[8];
            cnt_reg     <= w_cnt;
            dvd_reg     <= abs_sum[7:0];
            rem_reg     <= '0;
            quot_reg    <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? 4'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
            quot_reg    <= {quot_reg[BITS_W-2:0], trial_ge};
            dvd_reg     <= {dvd_reg[BITS_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 3'd1;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(err_val) * $signed({8'b0, steer_gain_reg});
        end
        if (cmd.cor)
        begin
            corr_reg <= corr_w[DUTY_W-1:0];
        end
        if (cmd.tgt)
        begin
            tl_reg <= tl_next;
            tr_reg <= tr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_now_reg   <= '0;
            right_now_reg  <= '0;
            last_err_reg   <= '0;
            cur_err_reg    <= '0;
            seen_reg       <= 1'b0;
            running_reg    <= 1'b0;
            dir_reg        <= DIR_STOP;
            out_valid_reg  <= 1'b0;
            line_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg  <= 1'b1;
                line_found_reg <= found_reg;
                if (is_stop)
                begin
                    left_now_reg  <= '0;
                    right_now_reg <= '0;
                    last_err_reg  <= '0;
                    cur_err_reg   <= '0;
                    seen_reg      <= 1'b0;
                    running_reg   <= 1'b0;
                    dir_reg       <= DIR_STOP;
                end
                else if (is_tick && running_reg)
                begin
                    left_now_reg  <= ramp_toward(left_now_reg, tl_reg, ramp_step_reg);
                    right_now_reg <= ramp_toward(right_now_reg, tr_reg, ramp_step_reg);
                    if (found_reg)
                    begin
                        cur_err_reg  <= err_val;
                        last_err_reg <= err_val;
                        seen_reg     <= 1'b1;
                        dir_reg      <= dir_of(err_val);
                    end
                    else
                    begin
                        cur_err_reg <= '0;
                        if (!seen_reg)
                            dir_reg <= DIR_FWD;
                        else if (last_err_reg < 0)
                            dir_reg <= DIR_LEFT;
                        else
                            dir_reg <= DIR_RIGHT;
                    end
                end
                else if (is_start && !running_reg)
                begin
                    left_now_reg  <= '0;
                    right_now_reg <= '0;
                    running_reg   <= 1'b1;
                    if (found_reg)
                    begin
                        cur_err_reg  <= err_val;
                        last_err_reg <= err_val;
                        seen_reg     <= 1'b1;
                        dir_reg      <= dir_of(err_val);
                    end
                    else
                    begin
                        cur_err_reg  <= '0;
                        last_err_reg <= '0;
                        seen_reg     <= 1'b0;
                        dir_reg      <= DIR_STOP;
                    end
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // State only moves at commit, which waits for a free result slot
    assign out_valid  = out_valid_reg;
    assign left_duty  = left_now_reg;
    assign right_duty = right_now_reg;
    assign line_error = cur_err_reg;
    assign heading    = dir_reg;
    assign line_found = line_found_reg;

endmodule

`default_nettype wire

### hw/rtl/line_follow_steering.sv
// Line-follow steering block: sequencer and datapath with a single result register.
// A control tick while armed runs the 8-step divider for the sensor average, then the
// multiply, correction and target states before commit; a start runs only the divider,
// a stop or an ignored request goes straight to commit. Commit waits for a free result
// register, and one request is in work at a time. Reset clears the follower state and
// loads the default configuration; the block takes requests right after reset.
`default_nettype none

module line_follow_steering (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lfs_pkg::FUNC_W-1:0]          func,
    input  logic [lfs_pkg::BITS_W-1:0]          sensor_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lfs_pkg::DUTY_W-1:0]   left_duty,
    output logic signed [lfs_pkg::DUTY_W-1:0]   right_duty,
    output logic signed [lfs_pkg::ERR_W-1:0]    line_error,
    output logic [lfs_pkg::HEAD_W-1:0]          heading,
    output logic                                line_found
);
    import lfs_pkg::*;

    lfs_cmd_t    cmd;
    lfs_status_t st;

    lfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lfs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .func        (func),
        .sensor_word (sensor_word),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .left_duty   (left_duty),
        .right_duty  (right_duty),
        .line_error  (line_error),
        .heading     (heading),
        .line_found  (line_found)
    );

    // A request is never taken back to back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous one still in work");

    // Commit always presents a result
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit did not raise out_valid");

    // Line error stays within the sensor weight span
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_error >= -7'sd35) && (line_error <= 7'sd35))
        else $error("line error out of range");

    // Stopped heading means both wheels at rest
    a_stop_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (heading == DIR_STOP) |-> ((left_duty == '0) && (right_duty == '0)))
        else $error("wheels moving while stopped");

endmodule

`default_nettype wire
